>>> sv/srx_pkg.sv
// ----------------------------------------------------------------------------
// srx_pkg
// Types, constants and the sRGB decoding table builder for the sRGB to XYZ
// converter.
// ----------------------------------------------------------------------------
package srx_pkg;

	localparam int unsigned LIN_FRAC_DEF = 16;
	localparam int unsigned LIN_W_MAX    = 25;
	localparam int unsigned COEF_W       = 16;
	localparam int unsigned XYZ_W        = 17;
	localparam int unsigned CODE_W       = 8;
	localparam int unsigned CODES        = 256;

	localparam int unsigned CURVE_DEN = 269025;
	localparam int unsigned CURVE_OFS = 14025;
	localparam int unsigned LIN_DEN   = 16473;
	localparam int unsigned LIN_DEN2  = 2 * LIN_DEN;
	localparam int unsigned BN_W      = 384;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [CODES-1:0][LIN_W_MAX-1:0] lin_table_t;

	// row-major, unsigned Q0.16
	localparam coef_t COEF [9] = '{
		16'd27027, 16'd23436, 16'd11829,
		16'd13933, 16'd46871, 16'd4732,
		16'd1265,  16'd7812,  16'd62292
	};

	typedef struct packed {
		logic [CODE_W-1:0] red_code;
		logic [CODE_W-1:0] green_code;
		logic [CODE_W-1:0] blue_code;
	} rgb_t;

	typedef struct packed {
		logic [XYZ_W-1:0] x_value;
		logic [XYZ_W-1:0] y_value;
		logic [XYZ_W-1:0] z_value;
	} xyz_t;

	// round(2^p * f(c/255)), exact; elaboration only
	function automatic logic [LIN_W_MAX-1:0] curve_entry(input int unsigned c,
			input int unsigned p);
		logic [BN_W-1:0] rhs;
		logic [BN_W-1:0] lhs;
		logic [63:0]     num;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     mid;
		int unsigned     n;
		if (c <= 10) begin
			num = (64'(5 * c) << (p + 1)) + 64'(LIN_DEN);
			return LIN_W_MAX'(num / LIN_DEN2);
		end
		if (c >= 255)
			return LIN_W_MAX'(1) << p;
		n   = 1000 * c + CURVE_OFS;
		rhs = BN_W'(1);
		for (int k = 0; k < 12; k++)
			rhs = rhs * BN_W'(n);
		rhs = rhs << (5 * p + 5);
		lo = 0;
		hi = (1 << p) + 1;
		while (hi - lo > 1) begin
			mid = lo + ((hi - lo) >> 1);
			lhs = BN_W'(1);
			for (int k = 0; k < 5; k++)
				lhs = lhs * BN_W'(2 * mid - 1);
			for (int k = 0; k < 12; k++)
				lhs = lhs * BN_W'(CURVE_DEN);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid;
		end
		return LIN_W_MAX'(lo);
	endfunction

	function automatic lin_table_t build_table(input int unsigned p);
		lin_table_t t;
		for (int unsigned c = 0; c < CODES; c++)
			t[c] = curve_entry(c, p);
		return t;
	endfunction

endpackage

>>> sv/srgb8_to_xyz_converter_top.sv
// ----------------------------------------------------------------------------
// srgb8_to_xyz_converter_top
// sRGB 8-bit pixel to CIE XYZ (D65), fixed point, three-stage pipeline.
// Throughput: one item per cycle unless a result waits under stall; set by the
// table read, the product stage and the row sum stage, each one register deep.
// Reset clears the valid bits only; the whole pipeline holds while a result
// waits under stall.
// ----------------------------------------------------------------------------
module srgb8_to_xyz_converter_top #(
	parameter int unsigned LINEAR_FRAC_BITS = srx_pkg::LIN_FRAC_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pixel_valid,
	output logic          pixel_stall,
	input  srx_pkg::rgb_t pixel,
	output logic          xyz_valid,
	input  logic          xyz_stall,
	output srx_pkg::xyz_t xyz
);
	import srx_pkg::*;

	logic                      en;
	logic                      vld_s1;
	logic                      vld_s2;
	logic                      vld_s3;
	logic [LINEAR_FRAC_BITS:0] lin_s1 [3];

	assign en          = !(vld_s3 && xyz_stall);
	assign pixel_stall = !en;
	assign xyz_valid   = vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pixel_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	srx_linearize #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_lin (
		.clk    (clk),
		.en     (en),
		.pixel  (pixel),
		.lin_s1 (lin_s1)
	);

	srx_matrix #(.LINEAR_FRAC_BITS(LINEAR_FRAC_BITS)) u_mat (
		.clk    (clk),
		.en     (en),
		.lin_s1 (lin_s1),
		.xyz_s3 (xyz)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_stall |=> vld_s1)
		else $error("accepted item lost at stage 1");

	a_s2_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && en |=> xyz_valid)
		else $error("item lost between stage 2 and output");

	a_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		xyz_valid |-> xyz.y_value <= XYZ_W'(65536))
		else $error("luminance above white");

endmodule

>>> sv/srx_linearize.sv
// ----------------------------------------------------------------------------
// srx_linearize
// Stage 1: sRGB decoding curve by constant table, one code per channel.
// ----------------------------------------------------------------------------
module srx_linearize #(
	parameter int unsigned LINEAR_FRAC_BITS = srx_pkg::LIN_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  srx_pkg::rgb_t             pixel,
	output logic [LINEAR_FRAC_BITS:0] lin_s1 [3]
);
	import srx_pkg::*;

	localparam lin_table_t LIN_TABLE = build_table(LINEAR_FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= LIN_TABLE[pixel.red_code][LINEAR_FRAC_BITS:0];
			lin_s1[1] <= LIN_TABLE[pixel.green_code][LINEAR_FRAC_BITS:0];
			lin_s1[2] <= LIN_TABLE[pixel.blue_code][LINEAR_FRAC_BITS:0];
		end
	end

endmodule

>>> sv/srx_matrix.sv
// ----------------------------------------------------------------------------
// srx_matrix
// Stages 2 and 3: nine products, then row sums rounded to Q1.16.
// ----------------------------------------------------------------------------
module srx_matrix #(
	parameter int unsigned LINEAR_FRAC_BITS = srx_pkg::LIN_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [LINEAR_FRAC_BITS:0] lin_s1 [3],
	output srx_pkg::xyz_t             xyz_s3
);
	import srx_pkg::*;

	localparam int unsigned PROD_W = LINEAR_FRAC_BITS + 1 + COEF_W;
	localparam int unsigned SUM_W  = PROD_W + 2;

	logic [PROD_W-1:0] prod_s2 [9];
	logic [SUM_W-1:0]  sum     [3];
	logic [SUM_W-1:0]  rnd     [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				prod_s2[i] <= PROD_W'(lin_s1[i % 3]) * PROD_W'(COEF[i]);
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SUM_W'(prod_s2[3*r]) + SUM_W'(prod_s2[3*r+1])
				+ SUM_W'(prod_s2[3*r+2]) + (SUM_W'(1) << (LINEAR_FRAC_BITS - 1));
			rnd[r] = sum[r] >> LINEAR_FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xyz_s3.x_value <= rnd[0][XYZ_W-1:0];
			xyz_s3.y_value <= rnd[1][XYZ_W-1:0];
			xyz_s3.z_value <= rnd[2][XYZ_W-1:0];
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Pixel stream test for the sRGB to XYZ converter. Pixels go in through the
// valid/stall handshake and the XYZ results come back in order. Each result
// is checked against a predictor that builds its own decoding table. Each
// table entry is estimated in floating point and then corrected by exact
// wide-integer comparison. Both sides idle at random, there is one long
// output hold-off, and the input is paused once until every result is back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import srx_pkg::*;

	localparam int unsigned FRAC      = LIN_FRAC_DEF;
	localparam int unsigned CURVE_D   = 269025;
	localparam int unsigned LATENCY   = 3;
	localparam int unsigned N_RANDOM  = 1560;

	logic  clk;
	logic  arst_n;
	logic  pixel_valid;
	logic  pixel_stall;
	rgb_t  pixel;
	logic  xyz_valid;
	logic  xyz_stall;
	xyz_t  xyz;

	logic [24:0] lin_lut [CODES];
	xyz_t        xyz_pending[$];
	int          n_errors;
	bit          quiet;
	int          hold_cycles;

	srgb8_to_xyz_converter_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel      (pixel),
		.xyz_valid  (xyz_valid),
		.xyz_stall  (xyz_stall),
		.xyz        (xyz)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	// true when (2y-1)/2 <= 2^FRAC * (n/D)^(12/5), exactly
	function automatic bit half_below(input int unsigned y, input int unsigned n);
		logic [383:0] lhs;
		logic [383:0] rhs;
		lhs = 384'(1);
		rhs = 384'(1);
		for (int k = 0; k < 5; k++)
			lhs = lhs * 384'(2 * y - 1);
		for (int k = 0; k < 12; k++) begin
			lhs = lhs * 384'(CURVE_D);
			rhs = rhs * 384'(n);
		end
		rhs = rhs << (5 * FRAC + 5);
		return lhs <= rhs;
	endfunction

	function automatic int unsigned decode_code(input int unsigned c);
		longint unsigned num;
		int unsigned     n;
		int unsigned     y;
		real             v;
		if (c <= 10) begin
			num = (longint'(5 * c) << (FRAC + 1)) + 16473;
			return int'(num / 32946);
		end
		if (c == 255)
			return 1 << FRAC;
		n = 1000 * c + 14025;
		v = $pow(real'(n) / real'(CURVE_D), 2.4) * real'(1 << FRAC);
		y = int'($floor(v + 0.5));
		if (y < 1)
			y = 1;
		while (half_below(y + 1, n))
			y++;
		while (y > 1 && !half_below(y, n))
			y--;
		return y;
	endfunction

	function automatic xyz_t predict_xyz(input rgb_t p);
		longint unsigned lin [3];
		longint unsigned acc;
		logic [16:0]     res [3];
		xyz_t            r;
		lin[0] = lin_lut[p.red_code];
		lin[1] = lin_lut[p.green_code];
		lin[2] = lin_lut[p.blue_code];
		for (int row = 0; row < 3; row++) begin
			acc = 0;
			for (int col = 0; col < 3; col++)
				acc += lin[col] * longint'(COEF[row * 3 + col]);
			acc = (acc + (64'd1 << (FRAC - 1))) >> FRAC;
			res[row] = acc[16:0];
		end
		r.x_value = res[0];
		r.y_value = res[1];
		r.z_value = res[2];
		return r;
	endfunction

	task automatic report(input string what, input logic [16:0] got, input logic [16:0] want);
		n_errors++;
		$display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		rgb_t p;
		p.red_code   = r;
		p.green_code = g;
		p.blue_code  = b;
		@(negedge clk);
		pixel       <= p;
		pixel_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!pixel_stall)
				break;
		end
		xyz_pending.push_back(predict_xyz(p));
		while (!quiet && $urandom_range(99) < 19) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
		end
	endtask

	task automatic send_random();
		send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
	endtask

	task automatic wait_drained();
		while (xyz_pending.size() != 0)
			@(posedge clk);
	endtask

	// output side stall
	initial begin
		xyz_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				xyz_stall <= 1'b1;
				hold_cycles--;
			end else if (quiet) begin
				xyz_stall <= 1'b0;
			end else begin
				xyz_stall <= ($urandom_range(99) < 19);
			end
		end
	end

	// result checker
	initial begin
		xyz_t want;
		forever begin
			@(posedge clk);
			if (xyz_valid && !xyz_stall) begin
				if (xyz_pending.size() == 0) begin
					report("unexpected item x", xyz.x_value, 17'd0);
				end else begin
					want = xyz_pending.pop_front();
					if (xyz.x_value !== want.x_value)
						report("x_value", xyz.x_value, want.x_value);
					if (xyz.y_value !== want.y_value)
						report("y_value", xyz.y_value, want.y_value);
					if (xyz.z_value !== want.z_value)
						report("z_value", xyz.z_value, want.z_value);
				end
			end
		end
	end

	task automatic test_corners();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd10,  8'd11,  8'd10);
		send_pixel(8'd11,  8'd10,  8'd11);
		send_pixel(8'd1,   8'd254, 8'd128);
		send_pixel(8'd254, 8'd1,   8'd127);
		send_pixel(8'h55,  8'hAA,  8'h55);
		send_pixel(8'hAA,  8'h55,  8'hAA);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		for (int c = 0; c <= 10; c++)
			send_pixel(8'(c * 25), 8'(c), 8'(255 - c));
	endtask

	task automatic test_random_flow();
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet = (i >= 400 && i < 600);
			send_random();
		end
		quiet = 1'b0;
	endtask

	task automatic test_output_holdoff();
		hold_cycles = 40;
		for (int i = 0; i < 20; i++)
			send_random();
	endtask

	task automatic test_input_pause();
		send_random();
		@(negedge clk);
		pixel_valid <= 1'b0;
		wait_drained();
		send_random();
	endtask

	initial begin
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		pixel       = '0;
		n_errors    = 0;
		quiet       = 1'b0;
		hold_cycles = 0;
		for (int c = 0; c < CODES; c++)
			lin_lut[c] = 25'(decode_code(c));
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corners();
		test_output_holdoff();
		test_input_pause();
		test_random_flow();

		@(negedge clk);
		pixel_valid <= 1'b0;
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
